// ----- src/bpdr_pkg.sv -----
// shared types and constants for the bmp pixel decode and rotate unit
`default_nettype none
package bpdr_pkg;

	localparam int DIM_W       = 13;
	localparam int PAL_DEPTH   = 256;
	localparam int PAL_AW      = 8;
	localparam int COLOR_W     = 24;
	localparam int COORD_W     = 17;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

	// opcodes
	localparam logic OP_PALETTE = 1'b0;
	localparam logic OP_PIXEL   = 1'b1;

	// pixel depth codes
	localparam logic [2:0] DEPTH_1BPP  = 3'd0;
	localparam logic [2:0] DEPTH_4BPP  = 3'd1;
	localparam logic [2:0] DEPTH_8BPP  = 3'd2;
	localparam logic [2:0] DEPTH_24BPP = 3'd3;
	localparam logic [2:0] DEPTH_32BPP = 3'd4;

	// rotation codes
	localparam logic [1:0] ROT_0   = 2'd0;
	localparam logic [1:0] ROT_90  = 2'd1;
	localparam logic [1:0] ROT_180 = 2'd2;
	localparam logic [1:0] ROT_270 = 2'd3;

	// configuration register indexes
	localparam logic [2:0] CFG_WIDTH    = 3'd0;
	localparam logic [2:0] CFG_HEIGHT   = 3'd1;
	localparam logic [2:0] CFG_DEPTH    = 3'd2;
	localparam logic [2:0] CFG_ROTATION = 3'd3;
	localparam logic [2:0] CFG_MIRROR   = 3'd4;
	localparam logic [2:0] CFG_ORIGIN_X = 3'd5;
	localparam logic [2:0] CFG_ORIGIN_Y = 3'd6;

	// effective configuration seen by front and back
	typedef struct packed {
		logic [DIM_W-1:0]   width;
		logic [DIM_W-1:0]   height;
		logic [2:0]         depth;
		logic [1:0]         rotation;
		logic               mirror;
		logic signed [15:0] origin_x;
		logic signed [15:0] origin_y;
	} cfg_t;

	// one queued job: a palette write, the pixels of one byte, or one assembled 24/32bpp pixel
	typedef struct packed {
		logic               pal_write;
		logic [3:0]         npix;
		logic [2:0]         depth;
		logic [7:0]         data;
		logic [DIM_W-1:0]   col;
		logic [DIM_W-1:0]   row;
		logic [COLOR_W-1:0] color;
	} entry_t;

endpackage
`default_nettype wire

// ----- src/bpdr_front.sv -----
// front end: accepts words, tracks row position and byte assembly, builds jobs
`default_nettype none
module bpdr_front import bpdr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               opcode,
	input  logic [7:0]         palette_index,
	input  logic [COLOR_W-1:0] palette_color,
	input  logic [7:0]         data_byte,
	input  logic               q_full,
	output logic               push,
	output entry_t             push_entry
);

	logic [DIM_W-1:0]   col_q;
	logic [DIM_W-1:0]   row_q;
	logic [14:0]        bir_q;
	logic [COLOR_W-1:0] partial_q;
	logic [1:0]         phase_q;

	logic               accept;
	logic               depth_ok;
	logic               byte_take;
	logic               in_row;
	logic [DIM_W-1:0]   remaining;
	logic [17:0]        row_bits;
	logic [14:0]        bpr;
	logic               row_end;
	logic               emit;
	logic [3:0]         npix;
	logic [COLOR_W-1:0] color;
	logic [1:0]         phase_n;
	logic [COLOR_W-1:0] partial_n;

	assign in_ready   = !q_full;
	assign accept     = in_valid && in_ready;
	assign depth_ok   = cfg.depth inside {[DEPTH_1BPP:DEPTH_32BPP]};
	assign byte_take  = accept && (opcode == OP_PIXEL) && depth_ok;
	assign in_row     = col_q < cfg.width;
	assign remaining  = cfg.width - col_q;

	// row length in bytes, padded to 4
	always_comb begin
		case (cfg.depth)
			DEPTH_1BPP:  row_bits = 18'(cfg.width) + 18'd31;
			DEPTH_4BPP:  row_bits = (18'(cfg.width) << 2) + 18'd31;
			DEPTH_8BPP:  row_bits = (18'(cfg.width) << 3) + 18'd31;
			DEPTH_24BPP: row_bits = (18'(cfg.width) << 4) + (18'(cfg.width) << 3) + 18'd31;
			DEPTH_32BPP: row_bits = (18'(cfg.width) << 5) + 18'd31;
			default:     row_bits = 18'd0;
		endcase
	end

	assign bpr     = {row_bits[17:5], 2'b00};
	assign row_end = ({1'b0, bir_q} + 16'd1) >= {1'b0, bpr};

	always_comb begin
		emit      = 1'b0;
		npix      = 4'd1;
		color     = '0;
		phase_n   = phase_q;
		partial_n = partial_q;
		if (in_row) begin
			case (cfg.depth)
				DEPTH_1BPP: begin
					emit = 1'b1;
					npix = (remaining >= 13'd8) ? 4'd8 : remaining[3:0];
				end
				DEPTH_4BPP: begin
					emit = 1'b1;
					npix = (remaining >= 13'd2) ? 4'd2 : 4'd1;
				end
				DEPTH_8BPP: begin
					emit = 1'b1;
				end
				DEPTH_24BPP: begin
					if (phase_q == 2'd0) begin
						partial_n = {16'd0, data_byte};
						phase_n   = 2'd1;
					end else if (phase_q == 2'd1) begin
						partial_n = partial_q | {8'd0, data_byte, 8'd0};
						phase_n   = 2'd2;
					end else begin
						// late phase completes the pixel with red
						emit      = 1'b1;
						color     = {data_byte, partial_q[15:0]};
						partial_n = '0;
						phase_n   = 2'd0;
					end
				end
				DEPTH_32BPP: begin
					if (phase_q == 2'd0) begin
						partial_n = {16'd0, data_byte};
						phase_n   = 2'd1;
					end else if (phase_q == 2'd1) begin
						partial_n = partial_q | {8'd0, data_byte, 8'd0};
						phase_n   = 2'd2;
					end else if (phase_q == 2'd2) begin
						partial_n = partial_q | {data_byte, 16'd0};
						phase_n   = 2'd3;
					end else begin
						// alpha byte dropped
						emit      = 1'b1;
						color     = partial_q;
						partial_n = '0;
						phase_n   = 2'd0;
					end
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			bir_q     <= '0;
			partial_q <= '0;
			phase_q   <= '0;
		end else if (byte_take) begin
			if (row_end) begin
				col_q     <= '0;
				bir_q     <= '0;
				partial_q <= '0;
				phase_q   <= '0;
				if (({1'b0, row_q} + 14'd1) >= {1'b0, cfg.height}) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + 13'd1;
				end
			end else begin
				bir_q     <= bir_q + 15'd1;
				col_q     <= emit ? (col_q + 13'(npix)) : col_q;
				partial_q <= partial_n;
				phase_q   <= phase_n;
			end
		end
	end

	assign push = accept && ((opcode == OP_PALETTE) || (depth_ok && emit));

	always_comb begin
		push_entry.pal_write = (opcode == OP_PALETTE);
		push_entry.npix      = npix;
		push_entry.depth     = cfg.depth;
		push_entry.data      = (opcode == OP_PALETTE) ? palette_index : data_byte;
		push_entry.col       = col_q;
		push_entry.row       = row_q;
		push_entry.color     = (opcode == OP_PALETTE) ? palette_color : color;
	end

endmodule
`default_nettype wire

// ----- src/bpdr_queue.sv -----
// short job queue between front and back
`default_nettype none
module bpdr_queue import bpdr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output logic   head_valid,
	output entry_t head
);

	entry_t              slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full       = count_q == (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- src/bpdr_back.sv -----
// back end: expands jobs into pixels, palette store, coordinate transform, output register
`default_nettype none
module bpdr_back import bpdr_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  logic                      head_valid,
	input  entry_t                    head,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [COORD_W-1:0] screen_x,
	output logic signed [COORD_W-1:0] screen_y,
	output logic [7:0]                red,
	output logic [7:0]                green,
	output logic [7:0]                blue,
	output logic                      last_of_item,
	output logic                      end_of_image
);

	logic [COLOR_W-1:0] pal_mem [PAL_DEPTH];

	logic [2:0]         k_q;
	logic               is_pix;
	logic               last_pix;
	logic               issue;
	logic               s1_free;
	logic               s2_load;
	logic [PAL_AW-1:0]  pal_idx;
	logic [DIM_W-1:0]   col;
	logic [COORD_W-1:0] x_val;
	logic [COORD_W-1:0] y_val;
	logic [COORD_W-1:0] wx;
	logic [COORD_W-1:0] hy;
	logic [COORD_W-1:0] tx;
	logic [COORD_W-1:0] ty;
	logic               eoi;

	logic               valid_s1;
	logic [COORD_W-1:0] tx_s1;
	logic [COORD_W-1:0] ty_s1;
	logic               pal_s1;
	logic [COLOR_W-1:0] color_s1;
	logic [COLOR_W-1:0] pal_rd_s1;
	logic               last_s1;
	logic               eoi_s1;

	logic               valid_s2;
	logic [COORD_W-1:0] x_s2;
	logic [COORD_W-1:0] y_s2;
	logic [COLOR_W-1:0] color_s2;
	logic               last_s2;
	logic               eoi_s2;

	assign s2_load  = valid_s1 && (!valid_s2 || out_ready);
	assign s1_free  = !valid_s1 || s2_load;
	assign is_pix   = head_valid && !head.pal_write;
	assign issue    = is_pix && s1_free;
	assign last_pix = ({1'b0, k_q} + 4'd1) == head.npix;
	assign pop      = head_valid && (head.pal_write || (issue && last_pix));

	// palette index for the pixel being expanded, msb first
	always_comb begin
		case (head.depth)
			DEPTH_1BPP: pal_idx = {7'd0, head.data[3'd7 - k_q]};
			DEPTH_4BPP: pal_idx = k_q[0] ? {4'd0, head.data[3:0]} : {4'd0, head.data[7:4]};
			default:    pal_idx = head.data;
		endcase
	end

	assign col   = head.col + 13'(k_q);
	assign x_val = 17'(col);
	assign y_val = 17'(head.row);
	assign wx    = 17'(cfg.width) - 17'd1 - x_val;
	assign hy    = 17'(cfg.height) - 17'd1 - y_val;
	assign eoi   = (({1'b0, col} + 14'd1) == {1'b0, cfg.width})
		&& (({1'b0, head.row} + 14'd1) == {1'b0, cfg.height});

	always_comb begin
		case (cfg.rotation)
			ROT_0: begin
				tx = cfg.mirror ? wx : x_val;
				ty = hy;
			end
			ROT_90: begin
				tx = cfg.mirror ? y_val : hy;
				ty = wx;
			end
			ROT_180: begin
				tx = cfg.mirror ? x_val : wx;
				ty = y_val;
			end
			ROT_270: begin
				tx = cfg.mirror ? hy : y_val;
				ty = x_val;
			end
			default: begin
				tx = x_val;
				ty = y_val;
			end
		endcase
	end

	// palette store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (head_valid && head.pal_write) begin
			pal_mem[head.data] <= head.color;
		end
		if (issue) begin
			pal_rd_s1 <= pal_mem[pal_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			tx_s1    <= tx;
			ty_s1    <= ty;
			pal_s1   <= (head.depth == DEPTH_1BPP) || (head.depth == DEPTH_4BPP)
				|| (head.depth == DEPTH_8BPP);
			color_s1 <= head.color;
			last_s1  <= last_pix;
			eoi_s1   <= eoi;
		end
		if (s2_load) begin
			x_s2     <= tx_s1 + {cfg.origin_x[15], cfg.origin_x};
			y_s2     <= ty_s1 + {cfg.origin_y[15], cfg.origin_y};
			color_s2 <= pal_s1 ? pal_rd_s1 : color_s1;
			last_s2  <= last_s1;
			eoi_s2   <= eoi_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (issue) begin
				k_q <= last_pix ? 3'd0 : (k_q + 3'd1);
			end
			if (s1_free) begin
				valid_s1 <= issue;
			end
			if (!valid_s2 || out_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	assign out_valid    = valid_s2;
	assign screen_x     = $signed(x_s2);
	assign screen_y     = $signed(y_s2);
	assign red          = color_s2[23:16];
	assign green        = color_s2[15:8];
	assign blue         = color_s2[7:0];
	assign last_of_item = last_s2;
	assign end_of_image = eoi_s2;

`ifndef SYNTHESIS
	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(head_valid && !head.pal_write) |-> ({1'b0, k_q} < head.npix))
		else $error("pixel counter beyond job pixel count");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s2_load) |=> valid_s1)
		else $error("stage one word lost while stalled");

	a_pal_write_pops: assert property (@(posedge clk) disable iff (!arst_n)
		(head_valid && head.pal_write) |-> (pop && !issue))
		else $error("palette write did not retire alone");

	a_k_clear_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !head.pal_write) |=> (k_q == 3'd0))
		else $error("pixel counter not cleared after job");
`endif

endmodule
`default_nettype wire

// ----- src/bmp_pixel_decode_rotate_unit.sv -----
// top level of the bmp pixel decode and rotate unit: config registers, front, queue, back
// path: an accepted byte is queued, then each pixel passes stage one and the output stage
// throughput: one input word per cycle while the queue is not full and each byte yields at
// most one pixel; a byte that expands to more than one pixel (1bpp up to 8, 4bpp up to 2)
// holds the back end at the single pixel issue port; the four-entry queue absorbs short bursts
// reset: arst_n clears counters, queue and pipeline valids and returns config to its defaults;
// the palette store is not cleared and holds garbage until each entry is written
`default_nettype none
module bmp_pixel_decode_rotate_unit import bpdr_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	// config write channel
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [2:0]                cfg_index,
	input  logic [15:0]               cfg_data,
	// input word channel
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      opcode,
	input  logic [7:0]                palette_index,
	input  logic [COLOR_W-1:0]        palette_color,
	input  logic [7:0]                data_byte,
	// output pixel channel
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [COORD_W-1:0] screen_x,
	output logic signed [COORD_W-1:0] screen_y,
	output logic [7:0]                red,
	output logic [7:0]                green,
	output logic [7:0]                blue,
	output logic                      last_of_item,
	output logic                      end_of_image
);

	// raw config registers
	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic [2:0]         depth_q;
	logic [1:0]         rotation_q;
	logic               mirror_q;
	logic signed [15:0] origin_x_q;
	logic signed [15:0] origin_y_q;

	cfg_t   cfg;
	logic   push;
	entry_t push_entry;
	logic   q_full;
	logic   pop;
	logic   head_valid;
	entry_t head;

	// config writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= 13'd1;
			height_q   <= 13'd1;
			depth_q    <= DEPTH_8BPP;
			rotation_q <= ROT_0;
			mirror_q   <= 1'b0;
			origin_x_q <= '0;
			origin_y_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WIDTH:    width_q    <= cfg_data[12:0];
				CFG_HEIGHT:   height_q   <= cfg_data[12:0];
				CFG_DEPTH:    depth_q    <= cfg_data[2:0];
				CFG_ROTATION: rotation_q <= cfg_data[1:0];
				CFG_MIRROR:   mirror_q   <= cfg_data[0];
				CFG_ORIGIN_X: origin_x_q <= $signed(cfg_data);
				CFG_ORIGIN_Y: origin_y_q <= $signed(cfg_data);
				default:      ;
			endcase
		end
	end

	// dimensions above the supported maximum act as the maximum
	always_comb begin
		cfg.width    = (width_q > MAX_DIM) ? MAX_DIM : width_q;
		cfg.height   = (height_q > MAX_DIM) ? MAX_DIM : height_q;
		cfg.depth    = depth_q;
		cfg.rotation = rotation_q;
		cfg.mirror   = mirror_q;
		cfg.origin_x = origin_x_q;
		cfg.origin_y = origin_y_q;
	end

	// front: row/column bookkeeping, byte assembly, job build
	bpdr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.palette_index (palette_index),
		.palette_color (palette_color),
		.data_byte     (data_byte),
		.q_full        (q_full),
		.push          (push),
		.push_entry    (push_entry)
	);

	// job queue decouples byte intake from pixel expansion
	bpdr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// back: palette lookup, transform, output register
	bpdr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.screen_x     (screen_x),
		.screen_y     (screen_y),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.last_of_item (last_of_item),
		.end_of_image (end_of_image)
	);

endmodule
`default_nettype wire
